@@ rtl/core/pae_pkg.sv @@
package pae_pkg;

  // field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned IDX_W    = 20;
  localparam int unsigned AREA_W   = 36;
  localparam int unsigned LEN_W    = 21;

  // record and buffer sizes
  localparam int unsigned MAX_RECORD_LEN  = 1048576;
  localparam int unsigned PULSE_BUF_DEPTH = 1024;
  localparam int unsigned BUF_AW          = $clog2(PULSE_BUF_DEPTH);
  localparam int unsigned CNT_W           = BUF_AW + 1;
  localparam int unsigned RAM_DEPTH       = 2 * PULSE_BUF_DEPTH;
  localparam int unsigned RAM_AW          = BUF_AW + 1;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_RECORD_LEN - 1);
  localparam logic [LEN_W-1:0] LEN_MAX  = {LEN_W{1'b1}};
  localparam logic [LEN_W-1:0] LEN_BUF  = LEN_W'(PULSE_BUF_DEPTH);

  // queue depths
  localparam int unsigned JOB_Q_DEPTH = 2;
  localparam int unsigned JOB_Q_AW    = $clog2(JOB_Q_DEPTH);

  typedef enum logic [1:0] {
    STATUS_VALID = 2'd0,
    STATUS_UNTERM = 2'd1,
    STATUS_LONG = 2'd2
  } status_e;

  // one closed or cut pulse on its way to the width counter
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] peak;
    logic [IDX_W-1:0]           peak_pos;
    logic [AREA_W-1:0]          area;
    logic [CNT_W-1:0]           len;
    status_e                    status;
    logic                       last;
    logic                       bank;
  } job_t;

  // buffer write port from the front
  typedef struct packed {
    logic                       we;
    logic [RAM_AW-1:0]          addr;
    logic [SAMPLE_W-1:0]        data;
  } ram_wr_t;

  // bank handed back by the width counter
  typedef struct packed {
    logic vld;
    logic bank;
  } rel_t;

endpackage

@@ rtl/core/pae_ram.sv @@
module pae_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/core/pae_job_queue.sv @@
module pae_job_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pae_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output pae_pkg::job_t job_o
);
  import pae_pkg::*;

  job_t                mem_q [JOB_Q_DEPTH];
  logic [JOB_Q_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [JOB_Q_AW:0]   count_q;

  assign full_o  = (count_q == (JOB_Q_AW + 1)'(JOB_Q_DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == JOB_Q_AW'(JOB_Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == JOB_Q_AW'(JOB_Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/pae_front.sv @@
module pae_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pae_pkg::SAMPLE_W-1:0]     cfg_wdata_i,
  input  logic                             push,
  output logic                             full,
  input  logic [pae_pkg::SAMPLE_W-1:0]     sample_i,
  input  logic                             last_i,
  output pae_pkg::ram_wr_t                 ram_wr_o,
  output logic                             job_push_o,
  output pae_pkg::job_t                    job_o,
  input  logic                             job_full_i,
  input  pae_pkg::rel_t                    rel_i
);
  import pae_pkg::*;

  logic signed [SAMPLE_W-1:0] thr_q, prev_q, peak_q, peak_d;
  logic [IDX_W-1:0]           idx_q, pidx_q, pidx_d;
  logic [AREA_W-1:0]          area_q, area_d;
  logic [LEN_W-1:0]           len_q, len_d, len_cur;
  logic                       pulse_open_q, cur_q;
  logic [1:0]                 busy_q, busy_d;

  logic signed [SAMPLE_W-1:0] s;
  logic                       accept, opening, closing, cont, cut;
  logic [AREA_W-1:0]          s_ext;

  assign s      = $signed(sample_i);
  assign s_ext  = {{(AREA_W - SAMPLE_W){sample_i[SAMPLE_W-1]}}, sample_i};
  assign full   = job_full_i || busy_q[cur_q];
  assign accept = push && !full;

  // classify the sample against the pulse state
  assign opening = !pulse_open_q && (idx_q != '0) && (s >= thr_q) && (prev_q < thr_q);
  assign closing = pulse_open_q && (s < thr_q);
  assign cont    = pulse_open_q && !closing;
  assign cut     = last_i && (opening || cont);

  // running pulse attributes
  always_comb begin
    len_cur = opening ? '0 : len_q;
    len_d   = (len_cur == LEN_MAX) ? len_cur : len_cur + 1'b1;
    area_d  = opening ? s_ext : area_q + s_ext;
    peak_d  = peak_q;
    pidx_d  = pidx_q;
    if (opening || (cont && (s > peak_q))) begin
      peak_d = s;
      pidx_d = idx_q;
    end
  end

  // sample store into the current bank
  assign ram_wr_o.we   = accept && (opening || pulse_open_q) && (len_cur < LEN_BUF);
  assign ram_wr_o.addr = {cur_q, len_cur[BUF_AW-1:0]};
  assign ram_wr_o.data = sample_i;

  // request to the width counter
  assign job_push_o = accept && (closing || cut);
  always_comb begin
    job_o.peak     = peak_d;
    job_o.peak_pos = pidx_d;
    job_o.area     = area_d;
    job_o.len      = len_d[CNT_W-1:0];
    job_o.last     = last_i;
    job_o.bank     = cur_q;
    if (cut) begin
      job_o.status = STATUS_UNTERM;
    end else if (len_d > LEN_BUF) begin
      job_o.status = STATUS_LONG;
    end else begin
      job_o.status = STATUS_VALID;
    end
  end

  // bank busy flags: set on handover, cleared on release
  always_comb begin
    busy_d = busy_q;
    if (rel_i.vld) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (accept && closing && (job_o.status == STATUS_VALID)) begin
      busy_d[cur_q] = 1'b1;
    end
  end

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_we_i) begin
      thr_q <= $signed(cfg_wdata_i);
    end
  end

  // front state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_open_q <= 1'b0;
      prev_q       <= '0;
      idx_q        <= '0;
      peak_q       <= '0;
      pidx_q       <= '0;
      area_q       <= '0;
      len_q        <= '0;
      cur_q        <= 1'b0;
      busy_q       <= '0;
    end else begin
      busy_q <= busy_d;
      if (accept) begin
        prev_q       <= s;
        idx_q        <= (last_i || idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
        pulse_open_q <= (opening || cont) && !last_i;
        if (opening || pulse_open_q) begin
          peak_q <= peak_d;
          pidx_q <= pidx_d;
          area_q <= area_d;
          len_q  <= len_d;
        end
        // hand the bank over when its samples are to be counted
        if (closing && job_o.status == STATUS_VALID) begin
          cur_q <= ~cur_q;
        end
      end
    end
  end

endmodule

@@ rtl/core/pae_back.sv @@
module pae_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            job_valid_i,
  input  pae_pkg::job_t                   job_i,
  output logic                            job_pop_o,
  output logic                            rd_en_o,
  output logic [pae_pkg::RAM_AW-1:0]      rd_addr_o,
  input  logic [pae_pkg::SAMPLE_W-1:0]    rd_data_i,
  output pae_pkg::rel_t                   rel_o,
  output logic                            empty,
  input  logic                            pop,
  output logic [pae_pkg::SAMPLE_W-1:0]    peak_o,
  output logic [pae_pkg::IDX_W-1:0]       peak_idx_o,
  output logic [pae_pkg::AREA_W-1:0]      area_o,
  output logic [pae_pkg::LEN_W-1:0]       width_count_o,
  output logic [1:0]                      status_o,
  output logic                            last_pulse_o
);
  import pae_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE,
    B_COUNT,
    B_DONE
  } bstate_e;

  typedef struct packed {
    job_t             job;
    logic [CNT_W-1:0] width;
  } res_t;

  bstate_e                    state_q;
  logic signed [SAMPLE_W-1:0] half_q, half_d;
  logic [CNT_W-1:0]           rd_cnt_q, wcnt_q;
  logic                       rd_vld_q;

  res_t       res_mem_q [2];
  logic       res_wr_q, res_rd_q;
  logic [1:0] res_cnt_q;
  logic       res_full, res_push;
  res_t       res_in;

  assign res_full = (res_cnt_q == 2'd2);

  // half of the peak, truncated toward zero
  assign half_d = ($signed(job_i.peak)
                   + $signed({{(SAMPLE_W - 1){1'b0}}, job_i.peak[SAMPLE_W-1]})) >>> 1;

  // read sweep over the stored pulse
  assign rd_en_o   = (state_q == B_COUNT) && (rd_cnt_q != job_i.len);
  assign rd_addr_o = {job_i.bank, rd_cnt_q[BUF_AW-1:0]};

  // finish a request: straight through, or after the count
  always_comb begin
    res_push = 1'b0;
    res_in.job   = job_i;
    res_in.width = '0;
    unique case (state_q)
      B_IDLE: begin
        res_push = job_valid_i && (job_i.status != STATUS_VALID) && !res_full;
      end
      B_DONE: begin
        res_push     = !res_full;
        res_in.width = wcnt_q;
      end
      default: begin
        res_push = 1'b0;
      end
    endcase
  end

  assign job_pop_o = res_push;
  assign rel_o.vld  = res_push && (state_q == B_DONE);
  assign rel_o.bank = job_i.bank;

  // width count sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      half_q   <= '0;
      rd_cnt_q <= '0;
      wcnt_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_en_o;
      unique case (state_q)
        B_IDLE: begin
          if (job_valid_i && job_i.status == STATUS_VALID) begin
            half_q   <= half_d;
            rd_cnt_q <= '0;
            wcnt_q   <= '0;
            state_q  <= B_COUNT;
          end
        end
        B_COUNT: begin
          if (rd_en_o) begin
            rd_cnt_q <= rd_cnt_q + 1'b1;
          end
          if (rd_vld_q && ($signed(rd_data_i) >= half_q)) begin
            wcnt_q <= wcnt_q + 1'b1;
          end
          if (!rd_en_o && !rd_vld_q) begin
            state_q <= B_DONE;
          end
        end
        B_DONE: begin
          if (!res_full) begin
            state_q <= B_IDLE;
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_mem_q[res_wr_q] <= res_in;
    end
  end

  // result queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wr_q  <= 1'b0;
      res_rd_q  <= 1'b0;
      res_cnt_q <= '0;
    end else begin
      if (res_push) begin
        res_wr_q <= ~res_wr_q;
      end
      if (pop && !empty) begin
        res_rd_q <= ~res_rd_q;
      end
      if (res_push && !(pop && !empty)) begin
        res_cnt_q <= res_cnt_q + 1'b1;
      end else if (!res_push && pop && !empty) begin
        res_cnt_q <= res_cnt_q - 1'b1;
      end
    end
  end

  // oldest result on the ports
  assign empty         = (res_cnt_q == '0);
  assign peak_o        = res_mem_q[res_rd_q].job.peak;
  assign peak_idx_o    = res_mem_q[res_rd_q].job.peak_pos;
  assign area_o        = res_mem_q[res_rd_q].job.area;
  assign width_count_o = LEN_W'(res_mem_q[res_rd_q].width);
  assign status_o      = res_mem_q[res_rd_q].job.status;
  assign last_pulse_o  = res_mem_q[res_rd_q].job.last;

endmodule

@@ rtl/core/pulse_attribute_extractor_core.sv @@
// A closed pulse goes to the request queue; its stored samples are read back and counted
// before its result enters the result queue; cut or over-long pulses pass straight through.
// Throughput: one sample per cycle; input stalls while the bank taken for the next pulse
// still holds a pulse being counted, or the request queue is full.
// Reset: asynchronous, clears threshold, pulse state and queues; buffer contents persist.
module pulse_attribute_extractor_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pae_pkg::SAMPLE_W-1:0]    cfg_wdata_i,
  input  logic                            push,
  output logic                            full,
  input  logic [pae_pkg::SAMPLE_W-1:0]    sample_i,
  input  logic                            last_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [pae_pkg::SAMPLE_W-1:0]    peak_o,
  output logic [pae_pkg::IDX_W-1:0]       peak_idx_o,
  output logic [pae_pkg::AREA_W-1:0]      area_o,
  output logic [pae_pkg::LEN_W-1:0]       width_count_o,
  output logic [1:0]                      status_o,
  output logic                            last_pulse_o
);
  import pae_pkg::*;

  ram_wr_t               ram_wr;
  logic                  job_push, job_full, job_pop, job_valid;
  job_t                  job_in, job_head;
  rel_t                  rel;
  logic                  rd_en;
  logic [RAM_AW-1:0]     rd_addr;
  logic [SAMPLE_W-1:0]   rd_data;

  // sample classification and pulse tracking
  pae_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .sample_i    (sample_i),
    .last_i      (last_i),
    .ram_wr_o    (ram_wr),
    .job_push_o  (job_push),
    .job_o       (job_in),
    .job_full_i  (job_full),
    .rel_i       (rel)
  );

  // two-bank pulse buffer
  pae_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RAM_DEPTH)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_wr.we),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // requests between front and back
  pae_job_queue u_jobs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .valid_o (job_valid),
    .job_o   (job_head)
  );

  // width counting and result queue
  pae_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (job_valid),
    .job_i         (job_head),
    .job_pop_o     (job_pop),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_data),
    .rel_o         (rel),
    .empty         (empty),
    .pop           (pop),
    .peak_o        (peak_o),
    .peak_idx_o    (peak_idx_o),
    .area_o        (area_o),
    .width_count_o (width_count_o),
    .status_o      (status_o),
    .last_pulse_o  (last_pulse_o)
  );

endmodule

@@ bench/pulse_attribute_extractor_core_tb.sv @@
// one expected or observed pulse result
typedef struct packed {
  logic [pae_pkg::SAMPLE_W-1:0] peak;
  logic [pae_pkg::IDX_W-1:0]    peak_idx;
  logic [pae_pkg::AREA_W-1:0]   area;
  logic [pae_pkg::LEN_W-1:0]    width_count;
  pae_pkg::status_e             status;
  logic                         last_pulse;
} pulse_attr_t;

// predicts pulse attributes from accepted samples and checks what comes out
class pulse_attr_scoreboard;
  logic signed [pae_pkg::SAMPLE_W-1:0] threshold;
  logic signed [pae_pkg::SAMPLE_W-1:0] prev_sample;
  logic signed [pae_pkg::SAMPLE_W-1:0] peak_val;
  logic [pae_pkg::IDX_W-1:0]           sample_idx;
  logic [pae_pkg::IDX_W-1:0]           peak_idx;
  logic signed [pae_pkg::AREA_W-1:0]   area_acc;
  logic [pae_pkg::LEN_W-1:0]           stored;
  logic signed [pae_pkg::SAMPLE_W-1:0] pulse_mem[pae_pkg::PULSE_BUF_DEPTH];
  bit                                  pulse_open;
  pulse_attr_t                         pending_pulses[$];
  int                                  mismatches;

  function new();
    threshold   = '0;
    prev_sample = '0;
    peak_val    = '0;
    sample_idx  = '0;
    peak_idx    = '0;
    area_acc    = '0;
    stored      = '0;
    pulse_open  = 1'b0;
    mismatches  = 0;
  endfunction

  function void set_threshold(logic signed [pae_pkg::SAMPLE_W-1:0] v);
    threshold = v;
  endfunction

  function int pending();
    return pending_pulses.size();
  endfunction

  function bit clean();
    return mismatches == 0 && pending_pulses.size() == 0;
  endfunction

  // add a sample to the area and the pulse memory
  function void keep(logic signed [pae_pkg::SAMPLE_W-1:0] s);
    if (stored < pae_pkg::LEN_BUF) pulse_mem[stored[pae_pkg::BUF_AW-1:0]] = s;
    if (stored != pae_pkg::LEN_MAX) stored++;
    area_acc = area_acc + s;
  endfunction

  function void emit(logic [pae_pkg::LEN_W-1:0] w, pae_pkg::status_e st, logic l);
    pulse_attr_t r;
    r.peak        = peak_val;
    r.peak_idx    = peak_idx;
    r.area        = area_acc;
    r.width_count = w;
    r.status      = st;
    r.last_pulse  = l;
    pending_pulses = {pending_pulses, r};
  endfunction

  // one accepted sample request
  function void note_sample(logic signed [pae_pkg::SAMPLE_W-1:0] s, logic l);
    int half;
    logic [pae_pkg::LEN_W-1:0] w;
    if (!pulse_open && sample_idx != 0 && s >= threshold && prev_sample < threshold) begin
      pulse_open = 1'b1;
      peak_val   = s;
      peak_idx   = sample_idx;
      area_acc   = '0;
      stored     = '0;
      keep(s);
    end else if (pulse_open && s < threshold) begin
      keep(s);
      if (stored > pae_pkg::LEN_BUF) begin
        emit('0, pae_pkg::STATUS_LONG, l);
      end else begin
        // truncating halve, then count samples at or above it
        half = int'(peak_val) / 2;
        w = '0;
        for (int j = 0; j < int'(stored); j++)
          if (int'(pulse_mem[j]) >= half) w++;
        emit(w, pae_pkg::STATUS_VALID, l);
      end
      pulse_open = 1'b0;
    end else if (pulse_open) begin
      if (s > peak_val) begin
        peak_val = s;
        peak_idx = sample_idx;
      end
      keep(s);
    end

    // pulse cut by record end
    if (l && pulse_open) begin
      emit('0, pae_pkg::STATUS_UNTERM, 1'b1);
      pulse_open = 1'b0;
    end

    prev_sample = s;
    if (l || sample_idx == pae_pkg::IDX_LAST) sample_idx = '0;
    else sample_idx++;
  endfunction

  function void flag(string what, logic [pae_pkg::AREA_W-1:0] want,
                     logic [pae_pkg::AREA_W-1:0] got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch on %s: expected %0h, got %0h", what, want, got);
  endfunction

  // one accepted result
  function void check_result(pulse_attr_t got);
    pulse_attr_t want;
    if (pending_pulses.size() == 0) begin
      flag("result with no pulse pending (peak)", '0, got.peak);
      return;
    end
    want = pending_pulses.pop_front();
    if (got.peak !== want.peak) flag("peak", want.peak, got.peak);
    if (got.peak_idx !== want.peak_idx)
      flag("peak index", want.peak_idx, got.peak_idx);
    if (got.area !== want.area) flag("area", want.area, got.area);
    if (got.width_count !== want.width_count)
      flag("width_count", want.width_count, got.width_count);
    if (got.status !== want.status) flag("status", want.status, got.status);
    if (got.last_pulse !== want.last_pulse) flag("last_pulse", want.last_pulse, got.last_pulse);
  endfunction
endclass

module pulse_attribute_extractor_core_tb;

  // cycles for the width counter to finish a full buffer
  localparam int SETTLE = pae_pkg::PULSE_BUF_DEPTH + 16;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         cfg_we_i    = 1'b0;
  logic [pae_pkg::SAMPLE_W-1:0] cfg_wdata_i = '0;
  logic                         push        = 1'b0;
  logic                         full;
  logic [pae_pkg::SAMPLE_W-1:0] sample_i    = '0;
  logic                         last_i      = 1'b0;
  logic                         empty;
  logic                         pop         = 1'b0;
  logic [pae_pkg::SAMPLE_W-1:0] peak_o;
  logic [pae_pkg::IDX_W-1:0]    peak_idx_o;
  logic [pae_pkg::AREA_W-1:0]   area_o;
  logic [pae_pkg::LEN_W-1:0]    width_count_o;
  logic [1:0]                   status_o;
  logic                         last_pulse_o;

  pulse_attr_scoreboard pulse_sb = new();

  int cur_thr   = 0;
  int items_sent = 0;
  int tx_streak = 0;
  bit tx_calm   = 1'b0;
  int rx_streak = 0;
  bit rx_calm   = 1'b0;

  always #2 clk_i = ~clk_i;

  pulse_attribute_extractor_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push          (push),
    .full          (full),
    .sample_i      (sample_i),
    .last_i        (last_i),
    .empty         (empty),
    .pop           (pop),
    .peak_o        (peak_o),
    .peak_idx_o    (peak_idx_o),
    .area_o        (area_o),
    .width_count_o (width_count_o),
    .status_o      (status_o),
    .last_pulse_o  (last_pulse_o)
  );

  // idle cycles before the next request, with stretches of none
  function automatic int next_gap(inout int streak, inout bit calm);
    if (streak == 0) begin
      calm   = ($urandom_range(0, 3) == 0);
      streak = $urandom_range(4, 40);
    end
    streak--;
    return calm ? 0 : int'($urandom_range(0, 7));
  endfunction

  function automatic logic signed [pae_pkg::SAMPLE_W-1:0] below_level();
    return 16'(-32768 + int'($urandom_range(0, cur_thr + 32767)));
  endfunction

  function automatic logic signed [pae_pkg::SAMPLE_W-1:0] above_level();
    return 16'(cur_thr + int'($urandom_range(0, 32767 - cur_thr)));
  endfunction

  // drive one sample request and wait until it is taken
  task automatic send_sample(input logic [pae_pkg::SAMPLE_W-1:0] s, input logic l);
    int gap;
    gap = next_gap(tx_streak, tx_calm);
    @(negedge clk_i);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push     <= 1'b1;
    sample_i <= s;
    last_i   <= l;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    pulse_sb.note_sample(s, l);
    items_sent++;
  endtask

  task automatic hold_input();
    @(negedge clk_i);
    push <= 1'b0;
  endtask

  // one record, last flag on its final sample
  task automatic send_seq(input logic signed [pae_pkg::SAMPLE_W-1:0] seq[$]);
    foreach (seq[k]) send_sample(seq[k], k == seq.size() - 1);
  endtask

  // baseline and pulse stretches with random content, sometimes pure noise
  task automatic send_record();
    logic signed [pae_pkg::SAMPLE_W-1:0] seq[$];
    int len;
    bit noisy;
    len   = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(2, 30);
    noisy = (cur_thr == -32768) || ($urandom_range(0, 4) == 0);
    while (seq.size() < len) begin
      if (noisy) begin
        seq = {seq, 16'($urandom)};
      end else begin
        repeat ($urandom_range(1, 4)) seq = {seq, below_level()};
        repeat ($urandom_range(1, 12)) seq = {seq, above_level()};
      end
    end
    seq = seq[0:len-1];
    send_seq(seq);
  endtask

  // pulse of n samples over threshold, closed or cut by record end
  task automatic send_long(input int n, input bit closed);
    logic signed [pae_pkg::SAMPLE_W-1:0] seq[$];
    seq = '{-5, -5};
    repeat (n) seq = {seq, above_level()};
    if (closed) seq = {seq, below_level()};
    send_seq(seq);
  endtask

  // idle the input, let results drain, then change the threshold
  task automatic write_threshold(input int v);
    hold_input();
    while (pulse_sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= 16'(v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    pulse_sb.set_threshold(16'(v));
    cur_thr = v;
  endtask

  // take one result request and check it
  task automatic take_result();
    int gap;
    pulse_attr_t got;
    gap = next_gap(rx_streak, rx_calm);
    @(negedge clk_i);
    if (gap > 0) begin
      pop <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pop <= 1'b1;
    @(posedge clk_i);
    while (empty) @(posedge clk_i);
    got.peak        = peak_o;
    got.peak_idx    = peak_idx_o;
    got.area        = area_o;
    got.width_count = width_count_o;
    got.status      = pae_pkg::status_e'(status_o);
    got.last_pulse  = last_pulse_o;
    pulse_sb.check_result(got);
  endtask

  // result side
  initial begin
    @(posedge rst_ni);
    forever take_result();
  end

  // sample side
  initial begin
    int target;
    int phase_thr[6];
    phase_thr = '{-32768, 32767, -1500, 2000, 0, 0};
    phase_thr[4] = int'($urandom_range(0, 65535)) - 32768;
    phase_thr[5] = int'($urandom_range(0, 65535)) - 32768;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed records at the reset threshold of zero
    // full-scale pulse with a repeated maximum, closed before record end
    send_seq('{-32768, 32767, 32767, -1, -2});
    // crossing at the first sample is ignored; open on equality, cut at record end
    send_seq('{5, 7, -3, 0, 100, 40});
    // pulse opening on the final sample
    send_seq('{-10, 20});
    // pulse closing on the final sample
    send_seq('{-1, 3, 1, 3, -32768});
    // pulse one sample past the buffer depth
    send_long(pae_pkg::PULSE_BUF_DEPTH, 1'b1);

    // random records over a range of thresholds
    foreach (phase_thr[p]) begin
      write_threshold(phase_thr[p]);
      target = items_sent + 20;
      while (items_sent < target) send_record();
    end

    hold_input();
    while (pulse_sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (pulse_sb.clean()) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
